// ===== design/one_shot_timer_bank_top_defines.svh =====
// Assertion macros shared by the timer bank checker.
// Depends on nothing; included by the checker file only.
`ifndef ONE_SHOT_TIMER_BANK_TOP_DEFINES_SVH
`define ONE_SHOT_TIMER_BANK_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OSTB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ostb: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OSTB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ostb: next-cycle check failed");

`endif

// ===== design/ostb_pkg.sv =====
// Shared constants, codes and control/status structs of the one-shot timer bank.
// Depends on nothing; used by every module of the block.
`default_nettype none

package ostb_pkg;

    // Bank size and derived widths.
    localparam int TIMER_COUNT = 16;
    localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CNT_W       = $clog2(TIMER_COUNT + 1);

    // Fixed field widths.
    localparam int OP_W     = 2;
    localparam int ID_W     = 16;
    localparam int TMO_W    = 31;
    localparam int TIME_W   = 32;
    localparam int NUM_W    = 6;
    localparam int FIRED_W  = 16;
    localparam int ARMED_W  = 7;

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    // Result codes.
    localparam logic KIND_STATUS    = 1'b0;
    localparam logic KIND_EXPIRY    = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // a request is taken this cycle
        logic scan;     // examine one timer of the expiry scan
        logic fire;     // expire the best timer found by the scan
        logic finish;   // end the tick, flush the held expiry as last
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic scan_last;   // scan is at the final timer
        logic best_valid;  // the scan found an expired timer
    } t_dp_status;

endpackage

`default_nettype wire

// ===== design/ostb_ctrl.sv =====
// Controller state machine of the one-shot timer bank.
// Depends on ostb_pkg; drives the command struct of ostb_datapath.
`default_nettype none

module ostb_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [ostb_pkg::OP_W-1:0]   i_op,
    input  wire ostb_pkg::t_dp_status        i_status,
    output logic                             o_in_ready,
    output ostb_pkg::t_ctl_cmd               o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

    t_state r_state;
    t_state n_state;

    // Command decode and next state.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = i_status.out_free;
                o_cmd.accept = i_in_valid && i_status.out_free;
                if (o_cmd.accept && (i_op == ostb_pkg::OP_TICK)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // The held expiry may need the output register, so wait for it.
                if (i_status.out_free) begin
                    if (i_status.best_valid) begin
                        o_cmd.fire = 1'b1;
                        n_state    = S_SCAN;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/ostb_datapath.sv =====
// Datapath of the one-shot timer bank: timer state, time base, expiry scan and
// output register. Depends on ostb_pkg; commanded by ostb_ctrl.
`default_nettype none

module ostb_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ostb_pkg::t_ctl_cmd              i_cmd,
    input  wire logic [ostb_pkg::OP_W-1:0]       i_op,
    input  wire logic [ostb_pkg::ID_W-1:0]       i_timer_id,
    input  wire logic [ostb_pkg::TMO_W-1:0]      i_timeout,
    input  wire logic                            i_out_ready,
    output ostb_pkg::t_dp_status                 o_status,
    output logic                                 o_out_valid,
    output logic                                 o_kind,
    output logic                                 o_status_bit,
    output logic [ostb_pkg::NUM_W-1:0]           o_timer_number,
    output logic [ostb_pkg::FIRED_W-1:0]         o_expiry_count,
    output logic [ostb_pkg::ARMED_W-1:0]         o_armed_count,
    output logic                                 o_last
);

    localparam int N      = ostb_pkg::TIMER_COUNT;
    localparam int IDX_W  = ostb_pkg::IDX_W;
    localparam int CNT_W  = ostb_pkg::CNT_W;
    localparam int TIME_W = ostb_pkg::TIME_W;
    localparam int FW     = ostb_pkg::FIRED_W;

    // Timer state.
    logic [N-1:0]          r_armed;
    logic [TIME_W-1:0]     r_deadline [N];
    logic [FW-1:0]         r_fired    [N];
    logic [TIME_W-1:0]     r_now;
    logic [CNT_W-1:0]      r_armed_count;

    // Scan state and the expiry held back until the next one is known.
    logic [IDX_W-1:0]      r_scan_idx;
    logic                  r_best_valid;
    logic [IDX_W-1:0]      r_best_idx;
    logic [TIME_W-1:0]     r_best_age;
    logic                  r_pend_valid;
    logic [IDX_W-1:0]      r_pend_idx;
    logic [FW-1:0]         r_pend_cnt;
    logic [CNT_W-1:0]      r_pend_armed;

    // Output register.
    logic                           r_out_valid;
    logic                           r_out_kind;
    logic                           r_out_status;
    logic [ostb_pkg::NUM_W-1:0]     r_out_num;
    logic [FW-1:0]                  r_out_cnt;
    logic [CNT_W-1:0]               r_out_armed;
    logic                           r_out_last;

    logic                  id_ok;
    logic [IDX_W-1:0]      req_idx;
    logic                  req_armed;
    logic                  is_arm;
    logic                  is_cancel;
    logic                  req_ok;
    logic [FW-1:0]         req_cnt;
    logic [TIME_W-1:0]     scan_age;
    logic                  scan_hit;
    logic                  scan_last;
    logic [FW-1:0]         best_cnt;
    logic [FW-1:0]         best_cnt_next;
    logic                  out_free;
    logic                  out_load;

    // Arm and cancel decode.
    always_comb begin
        id_ok     = i_timer_id < ostb_pkg::ID_W'(N);
        req_idx   = i_timer_id[IDX_W-1:0];
        req_armed = id_ok && r_armed[req_idx];
        is_arm    = i_op == ostb_pkg::OP_ARM;
        is_cancel = i_op == ostb_pkg::OP_CANCEL;
        req_ok    = is_arm ? (id_ok && !req_armed) : req_armed;
        req_cnt   = id_ok ? r_fired[req_idx] : '0;
    end

    // One timer per scan cycle: expired and strictly older than the best so far,
    // so the lowest number wins a tie.
    always_comb begin
        scan_age  = r_now - r_deadline[r_scan_idx];
        scan_hit  = r_armed[r_scan_idx] && !scan_age[TIME_W-1] &&
                    (!r_best_valid || (scan_age > r_best_age));
        scan_last = r_scan_idx == IDX_W'(N - 1);
    end

    // Saturating bump of the chosen timer's expiry count.
    always_comb begin
        best_cnt      = r_fired[r_best_idx];
        best_cnt_next = (best_cnt == {FW{1'b1}}) ? best_cnt : best_cnt + FW'(1);
    end

    // Output register handshake.
    always_comb begin
        out_free = !r_out_valid || i_out_ready;
        out_load = (i_cmd.accept && (is_arm || is_cancel)) ||
                   ((i_cmd.fire || i_cmd.finish) && r_pend_valid);
    end

    // Control state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed       <= '0;
            r_now         <= '0;
            r_armed_count <= '0;
            r_scan_idx    <= '0;
            r_best_valid  <= 1'b0;
            r_pend_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_fired[i] <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.accept) begin
                case (i_op)
                    ostb_pkg::OP_ARM: begin
                        if (req_ok) begin
                            r_armed[req_idx] <= 1'b1;
                            r_armed_count    <= r_armed_count + CNT_W'(1);
                        end
                    end
                    ostb_pkg::OP_CANCEL: begin
                        if (req_ok) begin
                            r_armed[req_idx] <= 1'b0;
                            r_armed_count    <= r_armed_count - CNT_W'(1);
                        end
                    end
                    ostb_pkg::OP_TICK: begin
                        r_now        <= r_now + TIME_W'(1);
                        r_scan_idx   <= '0;
                        r_best_valid <= 1'b0;
                        r_pend_valid <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.scan) begin
                if (scan_hit) begin
                    r_best_valid <= 1'b1;
                end
                r_scan_idx <= scan_last ? '0 : r_scan_idx + IDX_W'(1);
            end

            if (i_cmd.fire) begin
                r_armed[r_best_idx] <= 1'b0;
                r_fired[r_best_idx] <= best_cnt_next;
                r_armed_count       <= r_armed_count - CNT_W'(1);
                r_pend_valid        <= 1'b1;
                r_best_valid        <= 1'b0;
            end

            if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Deadline store, written on a successful arm.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && is_arm && req_ok) begin
            r_deadline[req_idx] <= r_now + TIME_W'(i_timeout);
        end
    end

    // Scan best, held expiry and output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && scan_hit) begin
            r_best_idx <= r_scan_idx;
            r_best_age <= scan_age;
        end
        if (i_cmd.fire) begin
            r_pend_idx   <= r_best_idx;
            r_pend_cnt   <= best_cnt_next;
            r_pend_armed <= r_armed_count - CNT_W'(1);
        end
        if (i_cmd.accept && (is_arm || is_cancel)) begin
            r_out_kind   <= ostb_pkg::KIND_STATUS;
            r_out_status <= req_ok ? ostb_pkg::STATUS_OK : ostb_pkg::STATUS_REFUSED;
            r_out_num    <= i_timer_id[ostb_pkg::NUM_W-1:0];
            r_out_cnt    <= req_cnt;
            r_out_last   <= 1'b1;
            if (req_ok) begin
                r_out_armed <= is_arm ? r_armed_count + CNT_W'(1)
                                      : r_armed_count - CNT_W'(1);
            end else begin
                r_out_armed <= r_armed_count;
            end
        end else if ((i_cmd.fire || i_cmd.finish) && r_pend_valid) begin
            r_out_kind   <= ostb_pkg::KIND_EXPIRY;
            r_out_status <= ostb_pkg::STATUS_OK;
            r_out_num    <= ostb_pkg::NUM_W'(r_pend_idx);
            r_out_cnt    <= r_pend_cnt;
            r_out_armed  <= r_pend_armed;
            r_out_last   <= i_cmd.finish;
        end
    end

    // Status to the controller and result ports.
    always_comb begin
        o_status.out_free   = out_free;
        o_status.scan_last  = scan_last;
        o_status.best_valid = r_best_valid;
        o_out_valid         = r_out_valid;
        o_kind              = r_out_kind;
        o_status_bit        = r_out_status;
        o_timer_number      = r_out_num;
        o_expiry_count      = r_out_cnt;
        o_armed_count       = ostb_pkg::ARMED_W'(r_out_armed);
        o_last              = r_out_last;
    end

endmodule

`default_nettype wire

// ===== design/one_shot_timer_bank_top.sv =====
// A bank of TIMER_COUNT one-shot timers on a tick time base. An arm or cancel
// request gives exactly one status result and is taken when the block is idle
// and the output register is free. A tick request advances time and then searches
// the bank for expired timers one timer per cycle over the deadline registers:
// each pass scans every timer and then decides, firing the best expired timer or
// ending the tick; the decision waits while the result side stalls. Expiries come
// oldest deadline first, ties by ascending number, and the final result of every
// request carries last. A tick with no expiry gives no result; op 3 is dropped.
// The block is ready again right after reset.
// Depends on ostb_pkg, ostb_ctrl and ostb_datapath.
`default_nettype none

module one_shot_timer_bank_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [ostb_pkg::OP_W-1:0]         i_op,
    input  wire logic [ostb_pkg::ID_W-1:0]         i_timer_id,
    input  wire logic [ostb_pkg::TMO_W-1:0]        i_timeout,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_kind,
    output logic                                   o_status,
    output logic [ostb_pkg::NUM_W-1:0]             o_timer_number,
    output logic [ostb_pkg::FIRED_W-1:0]           o_expiry_count,
    output logic [ostb_pkg::ARMED_W-1:0]           o_armed_count,
    output logic                                   o_last
);

    ostb_pkg::t_ctl_cmd   cmd;
    ostb_pkg::t_dp_status dp_status;

    // Sequencer of requests and expiry scan passes.
    ostb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_status   (dp_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Timer state, scan and result register.
    ostb_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_op           (i_op),
        .i_timer_id     (i_timer_id),
        .i_timeout      (i_timeout),
        .i_out_ready    (i_out_ready),
        .o_status       (dp_status),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_status_bit   (o_status),
        .o_timer_number (o_timer_number),
        .o_expiry_count (o_expiry_count),
        .o_armed_count  (o_armed_count),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ===== design/ostb_checker.sv =====
// Port-level checks of the one-shot timer bank, bound to the top level.
// Depends on ostb_pkg and one_shot_timer_bank_top_defines.svh.
`default_nettype none
`include "one_shot_timer_bank_top_defines.svh"

module ostb_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire logic                              o_kind,
    input wire logic                              o_status,
    input wire logic [ostb_pkg::NUM_W-1:0]        o_timer_number,
    input wire logic [ostb_pkg::FIRED_W-1:0]      o_expiry_count,
    input wire logic [ostb_pkg::ARMED_W-1:0]      o_armed_count,
    input wire logic                              o_last
);

    localparam int PAYLOAD_W = ostb_pkg::NUM_W + ostb_pkg::FIRED_W + ostb_pkg::ARMED_W + 3;
    localparam logic [ostb_pkg::ARMED_W-1:0] ARMED_MAX =
        ostb_pkg::ARMED_W'(ostb_pkg::TIMER_COUNT);

    logic                 out_stall;
    logic                 out_is_status;
    logic                 out_is_expiry;
    logic [PAYLOAD_W-1:0] out_payload;

    // Result qualifiers and the whole payload as one vector.
    always_comb begin
        out_stall     = o_out_valid && !i_out_ready;
        out_is_status = o_out_valid && (o_kind == ostb_pkg::KIND_STATUS);
        out_is_expiry = o_out_valid && (o_kind == ostb_pkg::KIND_EXPIRY);
        out_payload   = {o_kind, o_status, o_timer_number, o_expiry_count,
                         o_armed_count, o_last};
    end

    // A stalled result holds its payload.
    `OSTB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, (o_out_valid && $stable(out_payload)))

    // An arm or cancel answer is always the only result of its request.
    `OSTB_ASSERT_IMP(a_status_last, i_clk, i_rst_n, out_is_status, o_last)

    // An expiry is never refused and has counted at least itself.
    `OSTB_ASSERT_IMP(a_expiry_ok, i_clk, i_rst_n, out_is_expiry, (!o_status && (o_expiry_count != '0)))

    // The armed count never exceeds the bank size.
    `OSTB_ASSERT_IMP(a_armed_range, i_clk, i_rst_n, o_out_valid, (o_armed_count <= ARMED_MAX))

endmodule

bind one_shot_timer_bank_top ostb_checker u_ostb_checker (.*);

`default_nettype wire
